// ===== rtl/core/isat_pkg.sv =====
`timescale 1ns / 1ps
// Package for the interface source address table.
// Holds shared constants and types; no dependencies.
package isat_pkg;
	localparam int TableEntriesDef = 16;
	localparam int EntryW = 1 + 64 + 64 + 8 + 8 + 1;

	localparam logic [1:0] CmdAdd    = 2'd0;
	localparam logic [1:0] CmdDelete = 2'd1;
	localparam logic [1:0] CmdQuery  = 2'd2;
	localparam logic [1:0] CmdSelect = 2'd3;

	localparam logic [1:0] StOk      = 2'd0;
	localparam logic [1:0] StMiss    = 2'd1;
	localparam logic [1:0] StFull    = 2'd2;

	localparam logic [7:0] ScopeGlobal = 8'd0;
	localparam logic [7:0] ScopeLink   = 8'd253;
	localparam logic [7:0] ScopeHost   = 8'd254;

	typedef struct packed {
		logic        v6;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [7:0]  prefix;
		logic [7:0]  scope;
		logic        primary;
	} entry_t;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FIND  = 8'b0000_0010,
		S_FWAIT = 8'b0000_0100,
		S_ACT   = 8'b0000_1000,
		S_SHIFT = 8'b0001_0000,
		S_SWAIT = 8'b0010_0000,
		S_SEL   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	function automatic logic [127:0] prefix_mask(input logic v6, input logic [7:0] p);
		logic [127:0] m;
		m = '0;
		for (int b = 0; b < 128; b++) begin
			if (v6) m[127 - b] = (b < int'(p));
			else if (b < 32) m[31 - b] = (b < int'(p));
		end
		return m;
	endfunction
endpackage

// ===== rtl/core/isat_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module isat_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                            wdata,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                            rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/interface_source_address_table_unit.sv =====
`timescale 1ns / 1ps
// Top level of the interface source address table.
// Depends on isat_pkg and isat_ram.
//
// One command is in work at a time; s_tready is low until its result is taken.
// Every command scans the table from the start, reading each entry in S_FIND
// and checking it in S_FWAIT, since each read goes through the registered read
// port of the entry memory. A delete then moves each later entry down one place,
// reading it in S_SHIFT and writing it in S_SWAIT. No clearing pass is needed.
module interface_source_address_table_unit #(
	parameter int TableEntries = isat_pkg::TableEntriesDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tuser: command[1:0], is_ipv6[2]
	input  logic [2:0]   s_tuser,
	// tdata: addr_hi[63:0], addr_lo[127:64], subnet_len[135:128],
	// addr_scope[143:136], is_primary[144], zero fill
	input  logic [151:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: status[1:0], src_hi[65:2], src_lo[129:66], zero fill
	output logic [135:0] m_tdata
);
	localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
	localparam int CntW = $clog2(TableEntries + 1);

	isat_pkg::state_t state_q;
	logic [CntW-1:0] count_q, i_q, k_q;
	logic found_q, bv_q, fv_q;
	logic [1:0] cmd_q;
	isat_pkg::entry_t in_q, best_e_q, fb_e_q, rd;
	logic [7:0] dscope_q;
	logic [1:0] status_q;
	logic [63:0] shi_q, slo_q;

	logic we;
	logic [IdxW-1:0] waddr, raddr;
	isat_pkg::entry_t wdata;
	logic [isat_pkg::EntryW-1:0] rdata;

	isat_ram #(.Width(isat_pkg::EntryW), .Depth(TableEntries)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);
	assign rd = isat_pkg::entry_t'(rdata);

	assign s_tready = state_q == isat_pkg::S_IDLE;
	assign m_tvalid = state_q == isat_pkg::S_OUT;
	assign m_tdata = {6'd0, slo_q, shi_q, status_q};

	logic eq, match, skip, host, better_b, better_f;
	logic [127:0] mask;
	always_comb begin
		eq = rd.v6 == in_q.v6 && rd.hi == in_q.hi && rd.lo == in_q.lo;
		mask = isat_pkg::prefix_mask(rd.v6, rd.prefix);
		match = (((({rd.hi, rd.lo}) ^ ({in_q.hi, in_q.lo})) & mask) == '0)
			&& !(rd.v6 && rd.prefix > 8'd128);
		skip = rd.v6 != in_q.v6 ||
			(!in_q.v6 && (rd.lo == 64'd0 || rd.prefix > 8'd32));
		host = rd.prefix == (in_q.v6 ? 8'd128 : 8'd32);
		if (!bv_q) better_b = 1'b1;
		else if (rd.primary != best_e_q.primary) better_b = rd.primary;
		else if ((rd.scope == dscope_q) != (best_e_q.scope == dscope_q))
			better_b = rd.scope == dscope_q;
		else better_b = rd.prefix > best_e_q.prefix;
		if (!fv_q) better_f = 1'b1;
		else if (rd.primary != fb_e_q.primary) better_f = rd.primary;
		else if ((rd.scope == dscope_q) != (fb_e_q.scope == dscope_q))
			better_f = rd.scope == dscope_q;
		else better_f = rd.prefix > fb_e_q.prefix;
	end

	always_comb begin
		we = 1'b0;
		waddr = i_q[IdxW-1:0];
		wdata = rd;
		raddr = i_q[IdxW-1:0];
		unique case (state_q)
			isat_pkg::S_ACT: begin
				if (cmd_q == isat_pkg::CmdAdd && (found_q || count_q < CntW'(TableEntries))) begin
					we = 1'b1;
					waddr = found_q ? k_q[IdxW-1:0] : count_q[IdxW-1:0];
					wdata = in_q;
				end
			end
			isat_pkg::S_SWAIT: begin
				we = 1'b1;
				waddr = IdxW'(i_q - 1'b1);
			end
			default: ;
		endcase
	end

	logic [63:0] in_hi, in_lo;
	logic [7:0] ds;
	assign in_hi = s_tuser[2] ? s_tdata[63:0] : 64'd0;
	assign in_lo = s_tuser[2] ? s_tdata[127:64] : {32'd0, s_tdata[95:64]};
	always_comb begin
		if (!s_tuser[2]) begin
			if (in_lo[31:24] == 8'd127) ds = isat_pkg::ScopeHost;
			else if (in_lo[31:24] == 8'd169 && in_lo[23:16] == 8'd254) ds = isat_pkg::ScopeLink;
			else ds = isat_pkg::ScopeGlobal;
		end else if (in_hi[63:56] == 8'hfe && (in_hi[55:48] & 8'hc0) == 8'h80) ds = isat_pkg::ScopeLink;
		else if (in_hi == 64'd0 && in_lo == 64'd1) ds = isat_pkg::ScopeHost;
		else ds = isat_pkg::ScopeGlobal;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isat_pkg::S_IDLE;
			count_q <= '0;
			i_q <= '0;
		end else begin
			unique case (state_q)
				isat_pkg::S_IDLE: if (s_tvalid) begin
					i_q <= '0;
					state_q <= isat_pkg::S_FIND;
				end
				isat_pkg::S_FIND: begin
					if (i_q >= count_q || (cmd_q != isat_pkg::CmdSelect && found_q))
						state_q <= isat_pkg::S_ACT;
					else state_q <= isat_pkg::S_FWAIT;
				end
				isat_pkg::S_FWAIT: begin
					i_q <= i_q + 1'b1;
					state_q <= (cmd_q == isat_pkg::CmdSelect && !skip && match
						&& better_b && host) ? isat_pkg::S_ACT : isat_pkg::S_FIND;
					if (cmd_q != isat_pkg::CmdSelect && eq) state_q <= isat_pkg::S_ACT;
				end
				isat_pkg::S_ACT: begin
					state_q <= isat_pkg::S_OUT;
					if (cmd_q == isat_pkg::CmdAdd && !found_q && count_q < CntW'(TableEntries))
						count_q <= count_q + 1'b1;
					if (cmd_q == isat_pkg::CmdDelete && found_q) begin
						i_q <= k_q + 1'b1;
						state_q <= isat_pkg::S_SHIFT;
					end
				end
				isat_pkg::S_SHIFT: begin
					if (i_q >= count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= isat_pkg::S_OUT;
					end else state_q <= isat_pkg::S_SWAIT;
				end
				isat_pkg::S_SWAIT: begin
					i_q <= i_q + 1'b1;
					state_q <= isat_pkg::S_SHIFT;
				end
				isat_pkg::S_OUT: if (m_tready) state_q <= isat_pkg::S_IDLE;
				default: state_q <= isat_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			bv_q <= 1'b0;
			fv_q <= 1'b0;
		end else if (state_q == isat_pkg::S_IDLE) begin
			found_q <= 1'b0;
			bv_q <= 1'b0;
			fv_q <= 1'b0;
		end else if (state_q == isat_pkg::S_FWAIT) begin
			if (eq && !found_q) found_q <= 1'b1;
			if (cmd_q == isat_pkg::CmdSelect && !skip) begin
				if (match && better_b) bv_q <= 1'b1;
				else if (!match && better_f) fv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			isat_pkg::S_IDLE: begin
				cmd_q <= s_tuser[1:0];
				in_q <= '{v6: s_tuser[2], hi: in_hi, lo: in_lo, prefix: s_tdata[135:128],
					scope: s_tdata[143:136], primary: s_tdata[144]};
				dscope_q <= ds;
			end
			isat_pkg::S_FWAIT: begin
				if (eq && !found_q) k_q <= i_q;
				if (cmd_q == isat_pkg::CmdSelect && !skip) begin
					if (match && better_b) best_e_q <= rd;
					else if (!match && better_f) fb_e_q <= rd;
				end
			end
			isat_pkg::S_ACT: begin
				shi_q <= '0;
				slo_q <= '0;
				unique case (cmd_q)
					isat_pkg::CmdAdd:
						status_q <= (!found_q && count_q >= CntW'(TableEntries)) ?
							isat_pkg::StFull : isat_pkg::StOk;
					isat_pkg::CmdDelete, isat_pkg::CmdQuery:
						status_q <= found_q ? isat_pkg::StOk : isat_pkg::StMiss;
					isat_pkg::CmdSelect: begin
						status_q <= (bv_q || fv_q) ? isat_pkg::StOk : isat_pkg::StMiss;
						if (bv_q) begin
							shi_q <= best_e_q.hi;
							slo_q <= best_e_q.lo;
						end else if (fv_q) begin
							shi_q <= fb_e_q.hi;
							slo_q <= fb_e_q.lo;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end
endmodule
